>>> rtl/core/sact_pkg.sv
// shared types and constants of the set-associative cache tag controller
`default_nettype none

package sact_pkg;

   localparam int AGE_W      = 8;
   localparam int WCNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [AGE_W-1:0] AGE_MAX    = 8'hFF;
   localparam logic [2:0]       OFFSET_MAX = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_BACK_MODE = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [AGE_W-1:0] age;
   } meta_type;

   typedef struct packed {
      logic        pad;
      logic        memory_write;
      logic [31:0] writeback_address;
      logic        writeback_needed;
      logic        fill_needed;
      logic [2:0]  way;
      logic        hit;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/set_assoc_cache_tag_controller.sv
// top level of the set-associative cache tag controller
//
// req channel: one transaction per access, req_tdata is the byte address and
//   req_tuser is 1 for a write. rsp channel: one transaction per access with
//   hit, way, fill, dirty writeback with its block address and the
//   write-through memory write.
// csr port: csr_we writes csr_wdata into the register at csr_index in the same
//   cycle; write only while no access is in flight.
// flow: an access reads its set row, then does the compare and age search, then
//   writes back the set row in the tag and line-state memories and loads its
//   result. one access is processed at a time, so a new request is taken only
//   after the last one has written back its set row.
// reset: configuration returns to 8 ways, 6 index bits, 2 offset bits and
//   write-back mode; then a clearing pass writes every row of the line-state
//   memory with req_tready low.
// stall: a result waits in the output register while rsp_tready is low; one
//   more request is taken meanwhile and held in its update step until the
//   output register frees.
`default_nettype none

module set_assoc_cache_tag_controller #(
   parameter int MAX_WAYS   = 8,
   parameter int MAX_SETS   = 64,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [sact_pkg::REQ_DATA_W-1:0]     req_tdata,  // address[31:0]
   input  wire logic                                req_tuser,  // is_write
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // hit, way[2:0], fill_needed, writeback_needed, writeback_address[31:0],
   // memory_write, zero pad
   output logic [sact_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [sact_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sact_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SET_LG = $clog2(MAX_SETS + 1) - 1;
   localparam int TAG_W  = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
   localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - TAG_W);

   typedef logic [MAX_WAYS-1:0][TAG_W-1:0]            tag_row_type;
   typedef sact_pkg::meta_type [MAX_WAYS-1:0]         meta_row_type;

   // configuration
   logic [3:0] cfg_ways_ff;
   logic [2:0] cfg_index_bits_ff;
   logic [2:0] cfg_offset_bits_ff;
   logic       cfg_wb_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ways_ff        <= 4'd8;
         cfg_index_bits_ff  <= 3'd6;
         cfg_offset_bits_ff <= 3'd2;
         cfg_wb_mode_ff     <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            sact_pkg::CSR_WAYS_IN_USE:     cfg_ways_ff        <= csr_wdata[3:0];
            sact_pkg::CSR_INDEX_BITS:      cfg_index_bits_ff  <= csr_wdata[2:0];
            sact_pkg::CSR_OFFSET_BITS:     cfg_offset_bits_ff <= csr_wdata[2:0];
            sact_pkg::CSR_WRITE_BACK_MODE: cfg_wb_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [sact_pkg::WCNT_W-1:0] nways;
   logic [2:0]                  ob_eff;
   logic [2:0]                  ib_eff;
   logic [3:0]                  sh_in;
   logic [31:0]                 addr_m;
   logic [31:0]                 set_full;
   logic [31:0]                 tag_full;
   logic [SET_W-1:0]            set_in;
   logic [TAG_W-1:0]            tag_in;

   always_comb begin
      if (cfg_ways_ff == 4'd0) begin
         nways = sact_pkg::WCNT_W'(1);
      end else if (sact_pkg::WCNT_W'(cfg_ways_ff) > sact_pkg::WCNT_W'(MAX_WAYS)) begin
         nways = sact_pkg::WCNT_W'(MAX_WAYS);
      end else begin
         nways = sact_pkg::WCNT_W'(cfg_ways_ff);
      end
      ob_eff   = (cfg_offset_bits_ff > sact_pkg::OFFSET_MAX) ? sact_pkg::OFFSET_MAX
                                                             : cfg_offset_bits_ff;
      ib_eff   = (4'(cfg_index_bits_ff) > 4'(SET_LG)) ? 3'(SET_LG) : cfg_index_bits_ff;
      sh_in    = 4'(ob_eff) + 4'(ib_eff);
      addr_m   = req_tdata & ADDR_MASK;
      set_full = (addr_m >> ob_eff) & ~(32'hFFFF_FFFF << ib_eff);
      tag_full = addr_m >> sh_in;
      set_in   = set_full[SET_W-1:0];
      tag_in   = tag_full[TAG_W-1:0];
   end

   // control
   sact_pkg::state_type state_ff, state_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_take;
   logic                tag_we;
   logic                meta_we;
   logic                rsp_load;
   logic [SET_W-1:0]    wr_set;
   meta_row_type        meta_wdata;

   // access context
   logic [TAG_W-1:0]    tag_ff;
   logic [SET_W-1:0]    set_ff;
   logic [2:0]          ob_ff;
   logic [3:0]          sh_ff;
   logic                wr_ff;

   // memories
   tag_row_type         tag_mem [MAX_SETS];
   meta_row_type        meta_mem [MAX_SETS];
   tag_row_type         tag_rd_ff;
   meta_row_type        meta_rd_ff;

   // lookup results
   logic                hit_ff, hit_in;
   logic [WAY_W-1:0]    vic_ff, vic_in;
   logic                wb_ff, wb_in;
   logic [TAG_W-1:0]    vtag_ff, vtag_in;
   tag_row_type         tag_row_ff, tag_row_in;
   meta_row_type        meta_row_ff, meta_row_in;

   sact_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_tready   = 1'b0;
      tag_we       = 1'b0;
      meta_we      = 1'b0;
      rsp_load     = 1'b0;
      wr_set       = set_ff;
      meta_wdata   = meta_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         sact_pkg::ST_CLEAR: begin
            meta_we    = 1'b1;
            wr_set     = clr_ff;
            meta_wdata = '0;
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = sact_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         sact_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = sact_pkg::ST_LOOKUP;
            end
         end
         sact_pkg::ST_LOOKUP: begin
            state_in = sact_pkg::ST_UPDATE;
         end
         sact_pkg::ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               tag_we       = 1'b1;
               meta_we      = 1'b1;
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sact_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sact_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sact_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tag_ff <= tag_in;
         set_ff <= set_in;
         ob_ff  <= ob_eff;
         sh_ff  <= sh_in;
         wr_ff  <= req_tuser;
      end
   end

   // set rows: tag memory and line-state memory
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_set] <= tag_row_ff;
      end
      if (req_take) begin
         tag_rd_ff <= tag_mem[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[wr_set] <= meta_wdata;
      end
      if (req_take) begin
         meta_rd_ff <= meta_mem[set_in];
      end
   end

   // tag compare, aging and victim search
   always_comb begin
      logic [MAX_WAYS-1:0]             active;
      logic [MAX_WAYS-1:0]             match;
      logic [sact_pkg::AGE_W-1:0]      aged [MAX_WAYS];
      logic [sact_pkg::AGE_W-1:0]      oldest;
      logic [WAY_W-1:0]                hit_way;
      logic [WAY_W-1:0]                old_way;
      hit_way = '0;
      old_way = '0;
      oldest  = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         active[w] = sact_pkg::WCNT_W'(w) < nways;
         match[w]  = active[w] && meta_rd_ff[w].valid && (tag_rd_ff[w] == tag_ff);
         aged[w]   = (active[w] && (meta_rd_ff[w].age != sact_pkg::AGE_MAX))
                     ? meta_rd_ff[w].age + 1'b1 : meta_rd_ff[w].age;
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (active[w] && ((w == 0) || (aged[w] > oldest))) begin
            oldest  = aged[w];
            old_way = WAY_W'(w);
         end
      end
      hit_in  = |match;
      vic_in  = hit_in ? hit_way : old_way;
      wb_in   = !hit_in && meta_rd_ff[vic_in].valid && meta_rd_ff[vic_in].dirty;
      vtag_in = tag_rd_ff[vic_in];
      tag_row_in  = tag_rd_ff;
      meta_row_in = meta_rd_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (active[w]) begin
            meta_row_in[w].age = aged[w];
         end
      end
      meta_row_in[vic_in].age = '0;
      if (!hit_in) begin
         tag_row_in[vic_in]        = tag_ff;
         meta_row_in[vic_in].valid = 1'b1;
         meta_row_in[vic_in].dirty = 1'b0;
      end
      if (wr_ff && cfg_wb_mode_ff) begin
         meta_row_in[vic_in].dirty = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sact_pkg::ST_LOOKUP) begin
         hit_ff      <= hit_in;
         vic_ff      <= vic_in;
         wb_ff       <= wb_in;
         vtag_ff     <= vtag_in;
         tag_row_ff  <= tag_row_in;
         meta_row_ff <= meta_row_in;
      end
   end

   // result
   always_comb begin
      logic [31:0] vic_wide;
      vic_wide = 32'(vic_ff);
      rsp_data_in.pad               = 1'b0;
      rsp_data_in.memory_write      = wr_ff && !cfg_wb_mode_ff;
      rsp_data_in.writeback_address = wb_ff ? ((32'(vtag_ff) << sh_ff) | (32'(set_ff) << ob_ff))
                                            : 32'd0;
      rsp_data_in.writeback_needed  = wb_ff;
      rsp_data_in.fill_needed       = !hit_ff;
      rsp_data_in.way               = vic_wide[2:0];
      rsp_data_in.hit               = hit_ff;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sact_checker.sv
// port checker of the set-associative cache tag controller and its bind
`default_nettype none

module sact_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [sact_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // clearing pass follows reset
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready or result right after reset");

   // one access at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second req transaction taken back to back");

   // a fresh result follows a request that was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without matching request");

   // exactly one of hit and fill, writeback only on a fill
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] != rsp_tdata[4]) && (!rsp_tdata[5] || rsp_tdata[4]))
      else $error("inconsistent hit, fill and writeback flags");

endmodule

bind set_assoc_cache_tag_controller sact_checker u_sact_checker (.*);

`default_nettype wire
